[src/base64_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Base64 decoder assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define B64D_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");
// next-cycle implication
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");
`else
`define B64D_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character lookup of the Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int CHAR_W         = 8;
   localparam int CSR_W          = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CSR_W-1:0]  MAX_OUT_RESET = 16'd4096;
   localparam logic [CHAR_W-1:0] CHAR_PAD      = 8'd61;   // '='

   // closing status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_INVALID    = 2'd1;
   localparam logic [1:0] ST_BAD_LENGTH = 2'd2;
   localparam logic [1:0] ST_OVER_CAP   = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      logic [1:0] status_code;
      logic       last;
   } result_type;

   // results caused by one item, in output order from entry 0
   typedef struct packed {
      result_type [QUEUE_DEPTH-1:0] res;
      logic [2:0]                   count;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
         s.value = 6'(c - 8'd65);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         s.value = 6'(c - 8'd71);
      end else if (c >= 8'd48 && c <= 8'd57) begin
         s.value = 6'(c + 8'd4);
      end else if (c == 8'd43) begin
         s.value = 6'd62;
      end else if (c == 8'd47) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

[src/base64_decoder.sv]
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming Base64 decoder (standard alphabet, '=' padding) with status.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one ASCII character per item in tdata[7:0]; tlast marks the
//   final character of a string. rsp carries decoded bytes in tdata[7:0];
//   the closing item of a string has tuser = 1, its status code in
//   tdata[9:8] (ok, invalid character, bad length, over capacity) and tlast.
//   Drop the string's bytes whenever that status is not ok.
//   csr_wr_en / csr_wr_data set the capacity in decoded bytes; write it only
//   while no string is in flight.
//   Throughput is one character per cycle while the input register does not
//   hold. A character waits in the input register, is decoded there in a
//   single pass and loads the result register once that register frees up.
//   One character causes up to four results (three bytes and the status);
//   the result register hands them out one per cycle while rsp_tready is
//   high, and the input register holds only while a character with results
//   meets a result register that is not emptying.
// Reset:
//   Synchronous; clears all string state and sets the capacity to 4096.
// Stalls:
//   A low rsp_tready holds the head result stable and backs up into req.
// ----------------------------------------------------------------------------
`include "base64_decoder_defines.svh"

module base64_decoder #(
   parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // character input
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] char_code
   input  logic                        req_tlast,   // last_char
   // result output
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,   // [7:0] out_byte, [9:8] status_code
   output logic                        rsp_tuser,   // is_status
   output logic                        rsp_tlast,   // last
   // capacity register
   input  logic                        csr_wr_en,
   input  logic [b64d_pkg::CSR_W-1:0]  csr_wr_data
);
   import b64d_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;
   logic [CSR_W-1:0]  max_out_ff;

   bundle_type bundle;
   logic       q_free;
   logic       advance;
   logic       q_load;
   logic       req_fire;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_out_ff <= MAX_OUT_RESET;
      end else if (csr_wr_en) begin
         max_out_ff <= csr_wr_data;
      end
   end

   // retire the held character when it has no results or the queue frees up
   assign advance    = in_valid_ff && (bundle.count == 3'd0 || q_free);
   assign q_load     = advance && (bundle.count != 3'd0);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   b64d_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .max_out   (max_out_ff),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .step      (advance),
      .bundle    (bundle)
   );

   b64d_res_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (q_load),
      .bundle     (bundle),
      .free       (q_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a closing item is always a status with a zero data byte
   `B64D_ASSERT_IMPLIES(a_last_is_status, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser && rsp_tdata[7:0] == 8'd0)
   // the result register is loaded only when it empties
   `B64D_ASSERT_IMPLIES(a_load_when_free, clock, reset, q_load, q_free)
   // an empty input register always takes an item
   `B64D_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !in_valid_ff, req_tready)
   // a taken item is held for decode in the next cycle
   `B64D_ASSERT_NEXT(a_accept_holds, clock, reset, req_fire, in_valid_ff)

endmodule

[src/b64d_decode.sv]
// ----------------------------------------------------------------------------
// b64d_decode
// Per-string state and the single-pass decode of one character.
// ----------------------------------------------------------------------------
module b64d_decode #(
   parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [b64d_pkg::CSR_W-1:0]   max_out,
   input  logic [b64d_pkg::CHAR_W-1:0]  char_code,
   input  logic                         last_char,
   input  logic                         step,
   output b64d_pkg::bundle_type         bundle
);
   import b64d_pkg::*;

   localparam int CMP_W = (COUNT_BITS > CSR_W) ? COUNT_BITS : CSR_W;

   logic [23:0]           group_bits_ff, group_bits_in;
   logic [1:0]            group_pos_ff, group_pos_in;
   logic [1:0]            pad_seen_ff, pad_seen_in;
   logic [1:0]            error_ff, error_in;
   logic [COUNT_BITS-1:0] emitted_ff, emitted_in;

   sextet_type  sx;
   logic        bad;
   logic [5:0]  val;
   logic [1:0]  pad_nx;
   logic [1:0]  err_a;
   logic [1:0]  err_b;
   logic [23:0] bits_nx;
   logic [1:0]  nbytes;
   logic [1:0]  room;
   logic [1:0]  emit;
   logic [1:0]  pos_nx;
   logic [CMP_W-1:0] lim_max;
   logic [CMP_W-1:0] lim_top;
   logic [CMP_W-1:0] limit;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] diff;
   result_type  status_res;
   result_type  byte_res [3];

   always_comb begin
      sx     = sextet_of(char_code);
      bad    = 1'b0;
      val    = 6'd0;
      pad_nx = pad_seen_ff;
      if (char_code == CHAR_PAD) begin
         if (group_pos_ff == 2'd2 && pad_seen_ff == 2'd0) begin
            pad_nx = 2'd1;
         end else if (group_pos_ff == 2'd3 && pad_seen_ff <= 2'd1) begin
            pad_nx = pad_seen_ff + 2'd1;
         end else begin
            bad = 1'b1;
         end
      end else if (sx.valid) begin
         if (pad_seen_ff != 2'd0) begin
            bad = 1'b1;
         end else begin
            val = sx.value;
         end
      end else begin
         bad = 1'b1;
      end

      err_a   = bad ? ST_INVALID : error_ff;
      bits_nx = {group_bits_ff[17:0], val};
      nbytes  = (group_pos_ff == 2'd3) ? 2'd3 - pad_nx : 2'd0;

      // room left under the capacity and the counter's top value
      lim_max = CMP_W'(max_out);
      lim_top = CMP_W'({COUNT_BITS{1'b1}});
      limit   = (lim_max < lim_top) ? lim_max : lim_top;
      cnt_w   = CMP_W'(emitted_ff);
      diff    = limit - cnt_w;
      if (cnt_w >= limit) begin
         room = 2'd0;
      end else if (diff >= CMP_W'(3)) begin
         room = 2'd3;
      end else begin
         room = diff[1:0];
      end
      emit  = (nbytes < room) ? nbytes : room;
      err_b = (emit < nbytes && err_a == ST_OK) ? ST_OVER_CAP : err_a;

      pos_nx = group_pos_ff + 2'd1;

      status_res.out_byte  = 8'd0;
      status_res.is_status = 1'b1;
      status_res.last      = 1'b1;
      if (err_b == ST_INVALID) begin
         status_res.status_code = ST_INVALID;
      end else if (pos_nx != 2'd0) begin
         status_res.status_code = ST_BAD_LENGTH;
      end else begin
         status_res.status_code = err_b;
      end

      byte_res[0] = '{out_byte: bits_nx[23:16], is_status: 1'b0,
                      status_code: ST_OK, last: 1'b0};
      byte_res[1] = '{out_byte: bits_nx[15:8], is_status: 1'b0,
                      status_code: ST_OK, last: 1'b0};
      byte_res[2] = '{out_byte: bits_nx[7:0], is_status: 1'b0,
                      status_code: ST_OK, last: 1'b0};

      bundle.res[0] = (emit > 2'd0) ? byte_res[0] : status_res;
      bundle.res[1] = (emit > 2'd1) ? byte_res[1] : status_res;
      bundle.res[2] = (emit > 2'd2) ? byte_res[2] : status_res;
      bundle.res[3] = status_res;
      bundle.count  = {1'b0, emit} + {2'b00, last_char};

      // clear per-string state once the status goes out
      if (last_char) begin
         group_bits_in = '0;
         group_pos_in  = '0;
         pad_seen_in   = '0;
         error_in      = ST_OK;
         emitted_in    = '0;
      end else begin
         group_bits_in = bits_nx;
         group_pos_in  = pos_nx;
         pad_seen_in   = pad_nx;
         error_in      = err_b;
         emitted_in    = emitted_ff + COUNT_BITS'(emit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff <= '0;
         group_pos_ff  <= '0;
         pad_seen_ff   <= '0;
         error_ff      <= ST_OK;
         emitted_ff    <= '0;
      end else if (step) begin
         group_bits_ff <= group_bits_in;
         group_pos_ff  <= group_pos_in;
         pad_seen_ff   <= pad_seen_in;
         error_ff      <= error_in;
         emitted_ff    <= emitted_in;
      end
   end

endmodule

[src/b64d_res_queue.sv]
// ----------------------------------------------------------------------------
// b64d_res_queue
// Result register: holds one item's results; one goes out a cycle when ready.
// ----------------------------------------------------------------------------
module b64d_res_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  b64d_pkg::bundle_type bundle,
   output logic                 free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [7:0] out_byte, [9:8] status_code
   output logic                 rsp_tuser,   // is_status
   output logic                 rsp_tlast
);
   import b64d_pkg::*;

   result_type [QUEUE_DEPTH-1:0] res_ff, res_in;
   logic [2:0]                   count_ff, count_in;
   logic                         fire;

   always_comb begin
      fire = rsp_tvalid && rsp_tready;
      free = (count_ff == 3'd0) || (count_ff == 3'd1 && fire);
      res_in   = res_ff;
      count_in = count_ff;
      if (load) begin
         res_in   = bundle.res;
         count_in = bundle.count;
      end else if (fire) begin
         // advance the head
         for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            res_in[k] = res_ff[k+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {6'd0, res_ff[0].status_code, res_ff[0].out_byte};
   assign rsp_tuser  = res_ff[0].is_status;
   assign rsp_tlast  = res_ff[0].last;

endmodule

[tb/base64_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_tb
// Self-checking bench for the streaming Base64 decoder. A queue of encoded
// characters feeds a clocked driver. A clocked monitor compares every
// decoded byte and closing status with a bit-true decoder kept inside the
// bench. The run steps through several capacity settings and uses random
// idle cycles on both sides. One long receiver stall backs the block up
// into its input.
// ----------------------------------------------------------------------------
module base64_decoder_tb;
   import b64d_pkg::*;

   // --- run shape -----------------------------------------------------------
   localparam int PHASE_CHARS    = 24;    // minimum random characters per capacity phase
   localparam int HOLD_AFTER     = 25;    // results seen before the long stall
   localparam int HOLD_CYCLES    = 300;   // length of the long receiver stall
   localparam int SETTLE_CYCLES  = 4;     // idle cycles before a capacity write
   localparam int TAIL_CYCLES    = 8;     // idle cycles after the last result
   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any handshake

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [7:0] code;
      logic       last;
   } char_item_type;

   // --- DUT ports, all known from time zero ---------------------------------
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = '0;    // [7:0] char_code
   logic              req_tlast   = 1'b0;  // last_char
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [15:0]       rsp_tdata;           // [7:0] out_byte, [9:8] status_code
   logic              rsp_tuser;           // is_status
   logic              rsp_tlast;           // last
   logic              csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data = '0;

   base64_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // --- decoder state kept by the bench -------------------------------------
   logic [CSR_W-1:0] capacity = MAX_OUT_RESET;
   logic [23:0]      grp_bits = '0;   // sextets gathered so far
   logic [1:0]       grp_pos  = '0;   // place of the next character in its group
   logic [1:0]       pads     = '0;   // '=' accepted so far in this string
   logic [1:0]       pend_err = ST_OK;
   logic [15:0]      n_out    = '0;   // data bytes handed out in this string

   char_item_type  char_q [$];     // characters not yet offered
   result_type     decoded_q [$];  // decoded bytes and statuses still due

   // --- bookkeeping ---------------------------------------------------------
   int chars_queued  = 0;
   int chars_taken   = 0;
   int strings_sent  = 0;
   int results_seen  = 0;
   int bytes_checked = 0;
   int mismatches    = 0;
   int status_tally [4] = '{0, 0, 0, 0};
   int phases_run    = 1;
   int tx_gap = 0, tx_run = 0;
   int rx_gap = 0, rx_run = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_cycles = 0;
   char_item_type next_char;
   result_type want;

   // Map one character to {valid, value} by searching the alphabet.
   function automatic logic [6:0] b64_digit(input logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
         if (ALPHABET[8*(63-i) +: 8] == c) begin
            return {1'b1, 6'(i)};
         end
      end
      return 7'd0;
   endfunction

   function automatic logic [7:0] alpha_char(input int idx);
      return ALPHABET[8*(63-idx) +: 8];
   endfunction

   // Advance the decoder by one accepted character; queue what it must emit.
   task automatic decode_char(input logic [7:0] c, input logic lastc);
      logic [6:0] dig;
      logic [5:0] val;
      logic       bad;
      int         nbytes;
      result_type r;
      dig = b64_digit(c);
      val = 6'd0;
      bad = 1'b0;
      if (c == CHAR_PAD) begin
         // padding only in the last two places, at most two of them
         if (grp_pos == 2'd2 && pads == 2'd0) begin
            pads = 2'd1;
         end else if (grp_pos == 2'd3 && pads <= 2'd1) begin
            pads = pads + 2'd1;
         end else begin
            bad = 1'b1;
         end
      end else if (dig[6]) begin
         // any data character after padding is invalid and counts as zero
         if (pads != 2'd0) begin
            bad = 1'b1;
         end else begin
            val = dig[5:0];
         end
      end else begin
         bad = 1'b1;
      end
      if (bad) begin
         pend_err = ST_INVALID;
      end
      grp_bits = {grp_bits[17:0], val};

      if (grp_pos == 2'd3) begin
         nbytes = 3 - int'(pads);
         for (int k = 0; k < nbytes; k++) begin
            // drop bytes beyond capacity or beyond the counter's top value
            if (n_out < capacity && n_out != 16'hFFFF) begin
               r.out_byte    = grp_bits[23-8*k -: 8];
               r.is_status   = 1'b0;
               r.status_code = ST_OK;
               r.last        = 1'b0;
               decoded_q.push_back(r);
               n_out++;
            end else if (pend_err == ST_OK) begin
               pend_err = ST_OVER_CAP;
            end
         end
      end
      grp_pos = grp_pos + 2'd1;

      if (lastc) begin
         r.out_byte  = 8'd0;
         r.is_status = 1'b1;
         r.last      = 1'b1;
         if (pend_err == ST_INVALID) begin
            r.status_code = ST_INVALID;
         end else if (grp_pos != 2'd0) begin
            r.status_code = ST_BAD_LENGTH;
         end else begin
            r.status_code = pend_err;
         end
         decoded_q.push_back(r);
         // clear per-string state
         grp_bits = '0;
         grp_pos  = '0;
         pads     = '0;
         pend_err = ST_OK;
         n_out    = '0;
      end
   endtask

   // --- stimulus builders ---------------------------------------------------
   task automatic push_char(input logic [7:0] c, input logic lastc);
      char_item_type it;
      it.code = c;
      it.last = lastc;
      char_q.push_back(it);
      chars_queued++;
      if (lastc) begin
         strings_sent++;
      end
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], i == s.len() - 1);
      end
   endtask

   // Mostly well-formed strings with random content; the rest get noise
   // characters, a truncated tail or a misplaced pad.
   task automatic push_random_string();
      logic [7:0] txt [$];
      int kind, groups, npad, cut;
      kind   = $urandom_range(0, 9);
      groups = $urandom_range(1, 3);
      npad   = $urandom_range(0, 2);
      for (int i = 0; i < 4 * groups; i++) begin
         txt.push_back(alpha_char($urandom_range(0, 63)));
      end
      if (npad > 0) begin
         txt[txt.size()-1] = CHAR_PAD;
      end
      if (npad > 1) begin
         txt[txt.size()-2] = CHAR_PAD;
      end
      case (kind)
         7: begin
            repeat ($urandom_range(1, 3)) begin
               txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            end
         end
         8: begin
            cut = $urandom_range(1, 3);
            repeat (cut) begin
               txt.delete(txt.size() - 1);
            end
         end
         9: begin
            txt[$urandom_range(0, txt.size() - 1)] = CHAR_PAD;
         end
         default: ;
      endcase
      for (int i = 0; i < txt.size(); i++) begin
         push_char(txt[i], i == txt.size() - 1);
      end
   endtask

   // Hold until every character is taken and every result has come back.
   task automatic wait_drained();
      while (char_q.size() != 0 || req_tvalid || decoded_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write the capacity register; the block samples it at the next edge.
   task automatic write_capacity(input logic [CSR_W-1:0] v);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      capacity     = v;
   endtask

   // --- main sequence -------------------------------------------------------
   initial begin
      logic [CSR_W-1:0] cap_plan [5];
      int start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed strings at the reset capacity.
      push_text("TWFu");          // full group, three bytes
      push_text("TQ==");          // two pads, one byte
      push_text("+/9=");          // '+', '/', digit, one pad
      push_char("z", 1'b0);       // letter, out-of-alphabet code, pad, then data after pad
      push_char(8'hFF, 1'b0);
      push_char(CHAR_PAD, 1'b0);
      push_char("A", 1'b1);
      push_char(CHAR_PAD, 1'b0);  // pad in first place, zero code, short string
      push_char(8'h00, 1'b1);
      push_text("AB");            // bad length only
      push_text("QQ===");         // third pad falls in a new group and is invalid
      wait_drained();

      // Extremes first, then small capacities that force suppression.
      cap_plan[0] = 16'hFFFF;
      cap_plan[1] = 16'd1;
      cap_plan[2] = 16'd0;
      cap_plan[3] = 16'($urandom_range(2, 8));
      cap_plan[4] = 16'($urandom_range(9, 40));
      foreach (cap_plan[p]) begin
         write_capacity(cap_plan[p]);
         phases_run++;
         start = chars_queued;
         while (chars_queued - start < PHASE_CHARS) begin
            push_random_string();
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Decoded %0d characters in %0d strings over %0d capacity settings; %0d bytes checked.",
               chars_taken, strings_sent, phases_run, bytes_checked);
      $display("Closing status: ok %0d, invalid %0d, bad length %0d, over capacity %0d; %0d mismatches.",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3], mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // --- driver: offer queued characters with random gaps --------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // Predict on the edge that takes the character.
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            chars_taken++;
         end
         // Advance only when the current slot is free; otherwise hold it.
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (char_q.size() != 0) begin
               next_char = char_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_char.code;
               req_tlast  <= next_char.last;
               // draw the gap before the next character; some runs go gapless
               if (tx_run > 0) begin
                  tx_run--;
                  tx_gap = 0;
               end else if ($urandom_range(0, 7) == 0) begin
                  tx_run = $urandom_range(8, 24);
                  tx_gap = 0;
               end else begin
                  tx_gap = $urandom_range(0, 16);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // --- monitor: take results with random stalls and check them ------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected result byte=%02h code=%0d status=%b last=%b",
                           $realtime, rsp_tdata[7:0], rsp_tdata[9:8], rsp_tuser, rsp_tlast);
               end
            end else begin
               want = decoded_q.pop_front();
               if (want.is_status) begin
                  status_tally[want.status_code]++;
               end else begin
                  bytes_checked++;
               end
               if (rsp_tdata[7:0] !== want.out_byte || rsp_tuser !== want.is_status ||
                   rsp_tdata[9:8] !== want.status_code || rsp_tlast !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result mismatch: expected byte=%02h code=%0d status=%b last=%b, got byte=%02h code=%0d status=%b last=%b",
                              $realtime, want.out_byte, want.status_code, want.is_status,
                              want.last, rsp_tdata[7:0], rsp_tdata[9:8], rsp_tuser,
                              rsp_tlast);
                  end
               end
            end
            // draw the stall before the next result
            if (rx_run > 0) begin
               rx_run--;
               rx_gap = 0;
            end else if ($urandom_range(0, 7) == 0) begin
               rx_run = $urandom_range(8, 24);
               rx_gap = 0;
            end else begin
               rx_gap = $urandom_range(0, 16);
            end
         end
         // Once, stall for a long stretch so the block fills and backs up.
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // --- watchdog: end the run when no item moves for too long ---------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles without a handshake.", stall_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
